FILE: design/lms_adaptive_fir_identifier_top_defines.svh
// ----------------------------------------------------------------------------
// LMS adaptive FIR identifier assertion macros
// Shared concurrent assertion forms for the identifier's design files.
// ----------------------------------------------------------------------------
`ifndef LMS_ADAPTIVE_FIR_IDENTIFIER_TOP_DEFINES_SVH
`define LMS_ADAPTIVE_FIR_IDENTIFIER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LAFI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LAFI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/lafi_pkg.sv
// ----------------------------------------------------------------------------
// LMS adaptive FIR identifier package
// Types and fixed-point constants shared by the identifier's modules.
// ----------------------------------------------------------------------------
package lafi_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int ERR_W     = 17;
    localparam int STEP_W    = 16;
    localparam int WEIGHT_W  = 48;
    localparam int MUL_B_W   = 17;
    localparam int PROD_W    = 64;
    localparam int YINT_W    = 24;
    localparam int M_W       = 34;
    localparam int FRAC_BITS = 40;
    localparam int UPD_SHIFT = 12;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd45036;

    localparam logic signed [PROD_W:0] ACC_MAX_X = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [PROD_W:0] ACC_MIN_X = -65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [WEIGHT_W:0] W_MAX_X = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [WEIGHT_W:0] W_MIN_X = -49'sh0_8000_0000_0000;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_MAC_DRAIN,
        ST_TRUNC,
        ST_RESULT,
        ST_MUL_E,
        ST_UPD,
        ST_UPD_DRAIN,
        ST_SHIFT
    } t_state;

    typedef struct packed {
        logic idle;
        logic clear;
        logic issue;
        logic upd;
        logic trunc;
        logic result;
        logic mul_e;
        logic hist_we;
        logic shift;
    } t_seq_ctl;

endpackage

FILE: design/lafi_ram.sv
// ----------------------------------------------------------------------------
// LMS adaptive FIR identifier RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lafi_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 48,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/lafi_mul.sv
// ----------------------------------------------------------------------------
// LMS adaptive FIR identifier multiplier
// The one shared signed multiplier, 48 by 17 bits, with a registered product.
// ----------------------------------------------------------------------------
module lafi_mul
    import lafi_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [WEIGHT_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0]  i_b,
    output logic signed [PROD_W-1:0]   o_prod
);

    logic signed [WEIGHT_W+MUL_B_W-1:0] full;
    logic signed [PROD_W-1:0]           r_prod;

    // Every product this block forms fits in 64 bits.
    assign full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= full[PROD_W-1:0];
        end
    end

    assign o_prod = r_prod;

endmodule

FILE: design/lafi_seq.sv
// ----------------------------------------------------------------------------
// LMS adaptive FIR identifier sequencer
// Walks the clearing pass, the filter pass and the weight update pass.
// ----------------------------------------------------------------------------
module lafi_seq
    import lafi_pkg::*;
#(
    parameter int  TAP_COUNT = 256,
    localparam int AW        = $clog2(TAP_COUNT),
    localparam int HW        = (TAP_COUNT > 2) ? $clog2(TAP_COUNT - 1) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_fire,
    input  logic          i_pipe_busy,
    input  logic          i_out_free,
    output t_seq_ctl      o_ctl,
    output logic [AW-1:0] o_idx,
    output logic [HW-1:0] o_hist_raddr,
    output logic [HW-1:0] o_hist_waddr
);

    t_state        r_state, n_state;
    logic [AW-1:0] r_idx, n_idx;
    logic [HW-1:0] r_haddr, n_haddr;
    logic [HW-1:0] r_base, n_base;
    logic [HW-1:0] base_dec;
    logic          last;
    t_seq_ctl      ctl;

    assign last     = (r_idx == AW'(TAP_COUNT - 1));
    assign base_dec = (r_base == '0) ? HW'(TAP_COUNT - 2) : r_base - HW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
            r_haddr <= '0;
            r_base  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_haddr <= n_haddr;
            r_base  <= n_base;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:     if (last) n_state = ST_IDLE;
            ST_IDLE:      if (i_in_fire) n_state = ST_MAC;
            ST_MAC:       if (last) n_state = ST_MAC_DRAIN;
            ST_MAC_DRAIN: if (!i_pipe_busy) n_state = ST_TRUNC;
            ST_TRUNC:     n_state = ST_RESULT;
            ST_RESULT:    if (i_out_free) n_state = ST_MUL_E;
            ST_MUL_E:     n_state = ST_UPD;
            ST_UPD:       if (last) n_state = ST_UPD_DRAIN;
            ST_UPD_DRAIN: if (!i_pipe_busy) n_state = ST_SHIFT;
            ST_SHIFT:     n_state = ST_IDLE;
            default:      n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        ctl = '0;
        unique case (r_state)
            ST_CLEAR: begin
                ctl.clear   = 1'b1;
                ctl.hist_we = !last;
            end
            ST_IDLE:      ctl.idle = 1'b1;
            ST_MAC:       ctl.issue = 1'b1;
            ST_MAC_DRAIN: ctl = '0;
            ST_TRUNC:     ctl.trunc = 1'b1;
            ST_RESULT:    ctl.result = i_out_free;
            ST_MUL_E: begin
                ctl.mul_e = 1'b1;
                ctl.upd   = 1'b1;
            end
            ST_UPD: begin
                ctl.issue = 1'b1;
                ctl.upd   = 1'b1;
            end
            ST_UPD_DRAIN: ctl.upd = 1'b1;
            ST_SHIFT: begin
                ctl.shift   = 1'b1;
                ctl.hist_we = 1'b1;
            end
            default:      ctl = '0;
        endcase
    end

    // Tap i reads history entry i-1, which sits at base+i-1 in the ring.
    always_comb begin
        n_idx   = r_idx;
        n_haddr = r_haddr;
        n_base  = r_base;
        if (ctl.clear || ctl.issue) begin
            n_idx = last ? '0 : r_idx + AW'(1);
        end
        if ((ctl.idle && i_in_fire) || ctl.mul_e) begin
            n_haddr = r_base;
        end else if (ctl.issue && (r_idx != '0)) begin
            n_haddr = (r_haddr == HW'(TAP_COUNT - 2)) ? '0 : r_haddr + HW'(1);
        end
        if (ctl.shift) begin
            n_base = base_dec;
        end
    end

    assign o_ctl        = ctl;
    assign o_idx        = r_idx;
    assign o_hist_raddr = r_haddr;
    assign o_hist_waddr = ctl.shift ? base_dec : r_idx[HW-1:0];

endmodule

FILE: design/lms_adaptive_fir_identifier_top.sv
// ----------------------------------------------------------------------------
// LMS adaptive FIR identifier
// Fixed-point LMS adaptive FIR filter with one shared multiply-accumulate.
// ----------------------------------------------------------------------------
// Usage: each input beat carries one reference sample and one desired sample
// on a valid/ready channel. The block forms the FIR sum over TAP_COUNT taps
// with the current weights, then returns one output beat with the saturated
// filter output and the error, and afterwards adapts every weight.
// Ready stays low from acceptance until the weight update pass has ended.
// The shared 48x17 multiplier walks all taps twice, once for the filter
// sum and once for the weight update, and each pass runs through the memory
// read register and the multiplier's product register before it ends.
// The result sits in an output register, so a new item may be accepted while
// it waits. If the receiver stalls, the next item halts after its filter
// pass until the earlier result has been taken.
// After reset the block clears the weight and history memories, one entry a
// cycle, and keeps ready low meanwhile. The step size register returns to
// 45036 and may be written at any time the block is idle.
// ----------------------------------------------------------------------------
`include "lms_adaptive_fir_identifier_top_defines.svh"

module lms_adaptive_fir_identifier_top
    import lafi_pkg::*;
#(
    parameter int TAP_COUNT = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_reference_sample,
    input  logic signed [SAMPLE_W-1:0] i_desired_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_filter_output,
    output logic signed [ERR_W-1:0]    o_error_value,
    input  logic                       i_step_size_we,
    input  logic [STEP_W-1:0]          i_step_size
);

    localparam int AW = $clog2(TAP_COUNT);
    localparam int HW = (TAP_COUNT > 2) ? $clog2(TAP_COUNT - 1) : 1;

    t_seq_ctl      ctl;
    logic [AW-1:0] idx;
    logic [HW-1:0] hist_raddr, hist_waddr;
    logic          in_fire, out_free, pipe_busy;

    // Input sample, desired sample and step size.
    logic signed [SAMPLE_W-1:0] r_x0, r_d;
    logic [STEP_W-1:0]          r_step;

    // Tap pipeline: stage 1 holds memory read data, stage 2 the product.
    logic                       r_v1, r_t1, r_v2;
    logic [AW-1:0]              r_a1, r_a2;
    logic signed [WEIGHT_W-1:0] r_w2;

    logic signed [PROD_W-1:0]   r_acc;
    logic signed [YINT_W-1:0]   r_yint;
    logic signed [ERR_W-1:0]    r_e;
    logic signed [M_W-1:0]      r_m;
    logic                       r_m_load;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_y_out;
    logic signed [ERR_W-1:0]    r_e_out;

    logic signed [WEIGHT_W-1:0] w_rdata;
    logic signed [SAMPLE_W-1:0] h_rdata;
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [WEIGHT_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod;

    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic signed [WEIGHT_W-1:0] w_wdata;
    logic signed [SAMPLE_W-1:0] h_wdata;

    logic signed [PROD_W:0]     acc_sum;
    logic signed [PROD_W-1:0]   acc_sat;
    logic signed [PROD_W-1:0]   rnd;
    logic signed [PROD_W-1:0]   delta;
    logic signed [WEIGHT_W:0]   w_sum;
    logic signed [WEIGHT_W-1:0] w_new;
    logic signed [PROD_W-1:0]   trunc_sum;
    logic signed [YINT_W:0]     diff;
    logic signed [ERR_W-1:0]    e_sat;
    logic signed [SAMPLE_W-1:0] y_sat;

    assign in_fire    = i_in_valid && ctl.idle;
    assign out_free   = !r_out_valid || i_out_ready;
    assign pipe_busy  = r_v1 || r_v2;
    assign o_in_ready = ctl.idle;

    lafi_seq #(
        .TAP_COUNT (TAP_COUNT)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_fire    (in_fire),
        .i_pipe_busy  (pipe_busy),
        .i_out_free   (out_free),
        .o_ctl        (ctl),
        .o_idx        (idx),
        .o_hist_raddr (hist_raddr),
        .o_hist_waddr (hist_waddr)
    );

    // Weights, Q.40. The clearing pass and the update pass share the write port.
    assign w_we    = ctl.clear || (r_v2 && ctl.upd);
    assign w_waddr = ctl.clear ? idx : r_a2;
    assign w_wdata = ctl.clear ? '0 : w_new;

    lafi_ram #(
        .DEPTH (TAP_COUNT),
        .WIDTH (WEIGHT_W),
        .AW    (AW)
    ) u_weights (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (idx),
        .o_rdata (w_rdata)
    );

    // Past samples as a ring; the newest entry sits at the ring's base.
    assign h_wdata = ctl.shift ? r_x0 : '0;

    lafi_ram #(
        .DEPTH (TAP_COUNT - 1),
        .WIDTH (SAMPLE_W),
        .AW    (HW)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (ctl.hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (h_wdata),
        .i_raddr (hist_raddr),
        .o_rdata (h_rdata)
    );

    // Tap zero is the sample that just arrived, not a stored one.
    assign x1 = r_t1 ? r_x0 : h_rdata;

    // Operand selection for the shared multiplier: weight times sample per tap in
    // the filter pass, step size times error once per item, then mu*error times sample per tap.
    always_comb begin
        if (ctl.mul_e) begin
            mul_a = {{(WEIGHT_W-ERR_W){r_e[ERR_W-1]}}, r_e};
            mul_b = {1'b0, r_step};
        end else if (ctl.upd) begin
            mul_a = {{(WEIGHT_W-M_W){r_m[M_W-1]}}, r_m};
            mul_b = {x1[SAMPLE_W-1], x1};
        end else begin
            mul_a = w_rdata;
            mul_b = {x1[SAMPLE_W-1], x1};
        end
    end

    lafi_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (r_v1 || ctl.mul_e),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Accumulator saturates symmetrically at plus and minus (2^63 - 1).
    always_comb begin
        acc_sum = {r_acc[PROD_W-1], r_acc} + {prod[PROD_W-1], prod};
        if (acc_sum > ACC_MAX_X) begin
            acc_sat = ACC_MAX_X[PROD_W-1:0];
        end else if (acc_sum < ACC_MIN_X) begin
            acc_sat = ACC_MIN_X[PROD_W-1:0];
        end else begin
            acc_sat = acc_sum[PROD_W-1:0];
        end
    end

    // Weight increment rounds to nearest with ties upward, then the weight
    // saturates to 48 bits.
    always_comb begin
        rnd   = prod + PROD_W'(64'sd2048);
        delta = rnd >>> UPD_SHIFT;
        w_sum = {r_w2[WEIGHT_W-1], r_w2} + delta[WEIGHT_W:0];
        if (w_sum > W_MAX_X) begin
            w_new = W_MAX_X[WEIGHT_W-1:0];
        end else if (w_sum < W_MIN_X) begin
            w_new = W_MIN_X[WEIGHT_W-1:0];
        end else begin
            w_new = w_sum[WEIGHT_W-1:0];
        end
    end

    // Truncation toward zero: bias negative sums before the arithmetic shift.
    assign trunc_sum = r_acc + (r_acc[PROD_W-1] ? PROD_W'((64'sd1 <<< FRAC_BITS) - 1)
                                                : PROD_W'(0));

    always_comb begin
        diff = {{(YINT_W+1-SAMPLE_W){r_d[SAMPLE_W-1]}}, r_d}
             - {r_yint[YINT_W-1], r_yint};
        if (diff > 25'sd65535) begin
            e_sat = 17'sd65535;
        end else if (diff < -25'sd65536) begin
            e_sat = -17'sd65536;
        end else begin
            e_sat = diff[ERR_W-1:0];
        end
        if (r_yint > 24'sd32767) begin
            y_sat = 16'sd32767;
        end else if (r_yint < -24'sd32768) begin
            y_sat = -16'sd32768;
        end else begin
            y_sat = r_yint[SAMPLE_W-1:0];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_RESET;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_m_load    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_step_size_we) begin
                r_step <= i_step_size;
            end
            r_v1     <= ctl.issue;
            r_v2     <= r_v1;
            r_m_load <= ctl.mul_e;
            if (ctl.result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x0 <= i_reference_sample;
            r_d  <= i_desired_sample;
        end
        r_t1 <= (idx == '0);
        r_a1 <= idx;
        r_a2 <= r_a1;
        r_w2 <= w_rdata;
        if (in_fire) begin
            r_acc <= '0;
        end else if (r_v2 && !ctl.upd) begin
            r_acc <= acc_sat;
        end
        if (ctl.trunc) begin
            r_yint <= trunc_sum[PROD_W-1:FRAC_BITS];
        end
        if (ctl.result) begin
            r_e     <= e_sat;
            r_y_out <= y_sat;
            r_e_out <= e_sat;
        end
        if (r_m_load) begin
            r_m <= prod[M_W-1:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_filter_output = r_y_out;
    assign o_error_value   = r_e_out;

    `LAFI_ASSERT_SAME(a_ready_pipe_empty, i_clk, i_rst_n, o_in_ready, !pipe_busy, "ready while taps in flight")
    `LAFI_ASSERT_SAME(a_result_reg_free, i_clk, i_rst_n, ctl.result, out_free, "result overwrites a pending beat")
    `LAFI_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_fire, !o_in_ready, "ready right after an accepted beat")
    `LAFI_ASSERT_SAME(a_stage2_from_stage1, i_clk, i_rst_n, r_v2, $past(r_v1), "product stage without read stage")

endmodule
